@@ rtl/wpp_pkg.sv @@
// shared types, constants and helpers for the world point projection block
`timescale 1ns / 1ps
package wpp_pkg;

    localparam int DEF_GRID_WIDTH  = 512;
    localparam int DEF_GRID_HEIGHT = 512;
    localparam int DEPTH_EPS_RAW   = 65;
    localparam int DIV_STEPS       = 64;

    localparam logic [31:0] RST_FOCAL_X      = 32'd45875200;
    localparam logic [31:0] RST_FOCAL_Y      = 32'd45875200;
    localparam logic [31:0] RST_CENTER_X     = 32'd39321600;
    localparam logic [31:0] RST_CENTER_Y     = 32'd11796480;
    localparam logic [31:0] RST_GRID_X_ORG   = 32'h0000_0000;
    localparam logic [31:0] RST_GRID_Y_ORG   = 32'hFFEC_0000;
    localparam logic [31:0] RST_GRID_SCALE_X = 32'd655360;
    localparam logic [31:0] RST_GRID_SCALE_Y = 32'd655360;

    typedef enum logic [2:0] {
        CFG_FOCAL_X      = 3'd0,
        CFG_FOCAL_Y      = 3'd1,
        CFG_CENTER_X     = 3'd2,
        CFG_CENTER_Y     = 3'd3,
        CFG_GRID_X_ORG   = 3'd4,
        CFG_GRID_Y_ORG   = 3'd5,
        CFG_GRID_SCALE_X = 3'd6,
        CFG_GRID_SCALE_Y = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [47:0]        rot_row0;
        logic [47:0]        rot_row1;
        logic [47:0]        rot_row2;
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [30:0]        min_depth;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] image_u;
        logic signed [31:0] image_v;
        logic               image_ok;
        logic [8:0]         grid_col;
        logic [8:0]         grid_row;
        logic               grid_ok;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [30:0]        min_depth;
    } t_cam;

    typedef struct packed {
        logic       image_ok;
        logic       neg_u;
        logic       neg_v;
        logic [8:0] grid_col;
        logic [8:0] grid_row;
        logic       grid_ok;
    } t_side;

    // signed quotient with floor rounding, plus center, saturated to 32 bits
    function automatic logic [31:0] pix_finish(input logic [63:0] q, input logic nz,
                                               input logic neg, input logic [31:0] c);
        logic signed [65:0] val;
        logic signed [65:0] sum;
        val = $signed({2'b00, q});
        if (neg) begin
            val = -val - $signed({65'd0, nz});
        end
        sum = val + $signed({34'd0, c});
        if (sum > 66'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (sum < -66'sd2147483648) begin
            return 32'h8000_0000;
        end
        return sum[31:0];
    endfunction

endpackage

@@ rtl/wpp_transform.sv @@
// camera frame transform: difference, rotation products, sum and saturate
`timescale 1ns / 1ps
module wpp_transform (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  wpp_pkg::t_in_item i_item,
    output logic              o_valid,
    output wpp_pkg::t_cam     o_cam
);
    logic [2:0]         r_v;
    logic [47:0]        w_row [0:2];
    logic signed [31:0] w_pt  [0:2];
    logic signed [31:0] w_tr  [0:2];
    logic signed [15:0] r_rot [0:2][0:2];
    logic signed [32:0] r_diff [0:2];
    logic signed [48:0] r_prod [0:2][0:2];
    logic [30:0]        r_md1, r_md2;
    logic signed [50:0] w_sum [0:2];
    logic signed [50:0] w_sh  [0:2];
    logic signed [31:0] n_cam [0:2];
    wpp_pkg::t_cam      r_cam;

    assign w_row[0] = i_item.rot_row0;
    assign w_row[1] = i_item.rot_row1;
    assign w_row[2] = i_item.rot_row2;
    assign w_pt[0]  = i_item.point_x;
    assign w_pt[1]  = i_item.point_y;
    assign w_pt[2]  = i_item.point_z;
    assign w_tr[0]  = i_item.trans_x;
    assign w_tr[1]  = i_item.trans_y;
    assign w_tr[2]  = i_item.trans_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r_rot[i][k]  <= $signed(w_row[i][16*k +: 16]);
                    r_prod[i][k] <= r_rot[i][k] * r_diff[i];
                end
                r_diff[i] <= $signed({w_pt[i][31], w_pt[i]}) - $signed({w_tr[i][31], w_tr[i]});
            end
            r_md1 <= i_item.min_depth;
            r_md2 <= r_md1;
            r_cam <= '{x: n_cam[0], y: n_cam[1], z: n_cam[2], min_depth: r_md2};
        end
    end

    // column k of R, i.e. row k of R transposed
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sum[k] = 51'(r_prod[0][k]) + 51'(r_prod[1][k]) + 51'(r_prod[2][k]);
            w_sh[k]  = w_sum[k] >>> 14;
            if (w_sh[k] > 51'sd2147483647) begin
                n_cam[k] = 32'sh7FFF_FFFF;
            end else if (w_sh[k] < -51'sd2147483648) begin
                n_cam[k] = 32'sh8000_0000;
            end else begin
                n_cam[k] = w_sh[k][31:0];
            end
        end
    end

    assign o_valid = r_v[2];
    assign o_cam   = r_cam;

endmodule

@@ rtl/wpp_divider.sv @@
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module wpp_divider (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_num,
    input  logic [30:0] i_den,
    output logic [63:0] o_quo,
    output logic        o_rem_nz
);
    localparam int Steps = wpp_pkg::DIV_STEPS;

    logic [30:0] r_rem [0:Steps-1];
    logic [63:0] r_num [0:Steps-1];
    logic [63:0] r_quo [0:Steps-1];
    logic [30:0] r_den [0:Steps-1];

    for (genvar s = 0; s < Steps; s++) begin : g_step
        logic [30:0] w_rem_in;
        logic [63:0] w_num_in;
        logic [63:0] w_quo_in;
        logic [30:0] w_den_in;
        logic [31:0] w_trial;
        logic [31:0] w_diff;
        logic        w_ge;

        if (s == 0) begin : g_first
            assign w_rem_in = '0;
            assign w_num_in = i_num;
            assign w_quo_in = '0;
            assign w_den_in = i_den;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_num_in = r_num[s-1];
            assign w_quo_in = r_quo[s-1];
            assign w_den_in = r_den[s-1];
        end

        assign w_trial = {w_rem_in, w_num_in[63]};
        assign w_diff  = w_trial - {1'b0, w_den_in};
        assign w_ge    = w_trial >= {1'b0, w_den_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_ge ? w_diff[30:0] : w_trial[30:0];
                r_num[s] <= {w_num_in[62:0], 1'b0};
                r_quo[s] <= {w_quo_in[62:0], w_ge};
                r_den[s] <= w_den_in;
            end
        end
    end

    assign o_quo    = r_quo[Steps-1];
    assign o_rem_nz = |r_rem[Steps-1];

endmodule

@@ rtl/world_point_projection.sv @@
// world point projection top level: config registers, pinhole and grid pipeline
//
//  channel   direction  handshake                payload
//  input     in         i_valid / o_stall        i_data (t_in_item)
//  result    out        o_valid / i_stall        o_data (t_out_item)
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one item per cycle unless the output stalls; 3 transform stages, 2 stages of
// offset and multiply, 64 divider stages (one quotient bit each), output register
// the 64-stage divider sets the depth; no item depends on another
// synchronous active-low reset clears valid bits and loads the config registers with their reset values
// a stalled output freezes the whole pipeline; o_stall follows it in the same cycle
`timescale 1ns / 1ps
module world_point_projection #(
    parameter int GRID_WIDTH  = wpp_pkg::DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = wpp_pkg::DEF_GRID_HEIGHT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  wpp_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output wpp_pkg::t_out_item o_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    localparam int Steps = wpp_pkg::DIV_STEPS;

    logic [31:0] r_focal_x, r_focal_y, r_center_x, r_center_y;
    logic [31:0] r_grid_x_org, r_grid_y_org, r_grid_scale_x, r_grid_scale_y;

    logic               w_en;
    logic               w_t_valid;
    wpp_pkg::t_cam      w_cam;

    // offset stage
    logic               r4_v;
    logic               r4_img_ok, r4_neg_x, r4_neg_y, r4_dneg_x, r4_dneg_y;
    logic [31:0]        r4_mag_x, r4_mag_y, r4_dmag_x, r4_dmag_y;
    logic [30:0]        r4_z;
    logic signed [32:0] w_dx, w_dy;
    logic signed [31:0] w_org_x, w_org_y;

    // multiply stage
    logic               r5_v;
    logic               r5_img_ok, r5_neg_x, r5_neg_y, r5_dneg_x, r5_dneg_y;
    logic [63:0]        r5_prod_u, r5_prod_v, r5_prod_gx, r5_prod_gy;
    logic [30:0]        r5_z;

    logic [31:0]        w_cell_x, w_cell_y;
    logic               w_ok_x, w_ok_y, w_gok;
    wpp_pkg::t_side     w_side;

    logic               r_side_v [0:Steps-1];
    wpp_pkg::t_side     r_side   [0:Steps-1];

    logic [63:0]        w_quo_u, w_quo_v;
    logic               w_nz_u, w_nz_v;
    wpp_pkg::t_side     w_last;
    wpp_pkg::t_out_item n_out;
    logic               r_out_valid;
    wpp_pkg::t_out_item r_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x      <= wpp_pkg::RST_FOCAL_X;
            r_focal_y      <= wpp_pkg::RST_FOCAL_Y;
            r_center_x     <= wpp_pkg::RST_CENTER_X;
            r_center_y     <= wpp_pkg::RST_CENTER_Y;
            r_grid_x_org   <= wpp_pkg::RST_GRID_X_ORG;
            r_grid_y_org   <= wpp_pkg::RST_GRID_Y_ORG;
            r_grid_scale_x <= wpp_pkg::RST_GRID_SCALE_X;
            r_grid_scale_y <= wpp_pkg::RST_GRID_SCALE_Y;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (wpp_pkg::t_cfg_reg'(i_cfg_index))
                wpp_pkg::CFG_FOCAL_X:      r_focal_x      <= i_cfg_data;
                wpp_pkg::CFG_FOCAL_Y:      r_focal_y      <= i_cfg_data;
                wpp_pkg::CFG_CENTER_X:     r_center_x     <= i_cfg_data;
                wpp_pkg::CFG_CENTER_Y:     r_center_y     <= i_cfg_data;
                wpp_pkg::CFG_GRID_X_ORG:   r_grid_x_org   <= i_cfg_data;
                wpp_pkg::CFG_GRID_Y_ORG:   r_grid_y_org   <= i_cfg_data;
                wpp_pkg::CFG_GRID_SCALE_X: r_grid_scale_x <= i_cfg_data;
                wpp_pkg::CFG_GRID_SCALE_Y: r_grid_scale_y <= i_cfg_data;
            endcase
        end
    end

    assign w_en    = !(r_out_valid && i_stall);
    assign o_stall = !w_en;

    wpp_transform u_transform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_item  (i_data),
        .o_valid (w_t_valid),
        .o_cam   (w_cam)
    );

    assign w_org_x = $signed(r_grid_x_org);
    assign w_org_y = $signed(r_grid_y_org);
    assign w_dx    = $signed({w_cam.x[31], w_cam.x}) - $signed({w_org_x[31], w_org_x});
    assign w_dy    = $signed({w_cam.y[31], w_cam.y}) - $signed({w_org_y[31], w_org_y});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v        <= 1'b0;
            r5_v        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < Steps; s++) begin
                r_side_v[s] <= 1'b0;
            end
        end else if (w_en) begin
            r4_v        <= w_t_valid;
            r5_v        <= r4_v;
            r_side_v[0] <= r5_v;
            for (int s = 1; s < Steps; s++) begin
                r_side_v[s] <= r_side_v[s-1];
            end
            r_out_valid <= r_side_v[Steps-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_img_ok <= (w_cam.z > $signed({1'b0, w_cam.min_depth}))
                         && (w_cam.z > 32'(wpp_pkg::DEPTH_EPS_RAW));
            r4_neg_x  <= w_cam.x[31];
            r4_neg_y  <= w_cam.y[31];
            r4_mag_x  <= w_cam.x[31] ? 32'(-w_cam.x) : 32'(w_cam.x);
            r4_mag_y  <= w_cam.y[31] ? 32'(-w_cam.y) : 32'(w_cam.y);
            r4_z      <= w_cam.z[30:0];
            r4_dneg_x <= w_dx[32];
            r4_dneg_y <= w_dy[32];
            r4_dmag_x <= w_dx[32] ? 32'(-w_dx) : 32'(w_dx);
            r4_dmag_y <= w_dy[32] ? 32'(-w_dy) : 32'(w_dy);

            r5_img_ok  <= r4_img_ok;
            r5_neg_x   <= r4_neg_x;
            r5_neg_y   <= r4_neg_y;
            r5_dneg_x  <= r4_dneg_x;
            r5_dneg_y  <= r4_dneg_y;
            r5_z       <= r4_z;
            r5_prod_u  <= r_focal_x * r4_mag_x;
            r5_prod_v  <= r_focal_y * r4_mag_y;
            r5_prod_gx <= r4_dmag_x * r_grid_scale_x;
            r5_prod_gy <= r4_dmag_y * r_grid_scale_y;

            r_side[0] <= w_side;
            for (int s = 1; s < Steps; s++) begin
                r_side[s] <= r_side[s-1];
            end
            r_out <= n_out;
        end
    end

    // negative offset with nonzero product lands outside the grid
    assign w_cell_x = r5_prod_gx[63:32];
    assign w_cell_y = r5_prod_gy[63:32];
    assign w_ok_x   = !(r5_dneg_x && (|r5_prod_gx)) && (w_cell_x < 32'(GRID_WIDTH));
    assign w_ok_y   = !(r5_dneg_y && (|r5_prod_gy)) && (w_cell_y < 32'(GRID_HEIGHT));
    assign w_gok    = w_ok_x && w_ok_y;

    always_comb begin
        w_side.image_ok = r5_img_ok;
        w_side.neg_u    = r5_neg_x;
        w_side.neg_v    = r5_neg_y;
        w_side.grid_ok  = w_gok;
        w_side.grid_col = w_gok ? w_cell_x[8:0] : 9'd0;
        w_side.grid_row = w_gok ? w_cell_y[8:0] : 9'd0;
    end

    wpp_divider u_div_u (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_num    (r5_prod_u),
        .i_den    (r5_z),
        .o_quo    (w_quo_u),
        .o_rem_nz (w_nz_u)
    );

    wpp_divider u_div_v (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_num    (r5_prod_v),
        .i_den    (r5_z),
        .o_quo    (w_quo_v),
        .o_rem_nz (w_nz_v)
    );

    assign w_last = r_side[Steps-1];

    always_comb begin
        n_out.image_ok = w_last.image_ok;
        n_out.image_u  = w_last.image_ok
                         ? $signed(wpp_pkg::pix_finish(w_quo_u, w_nz_u, w_last.neg_u, r_center_x))
                         : 32'sd0;
        n_out.image_v  = w_last.image_ok
                         ? $signed(wpp_pkg::pix_finish(w_quo_v, w_nz_v, w_last.neg_v, r_center_y))
                         : 32'sd0;
        n_out.grid_col = w_last.grid_col;
        n_out.grid_row = w_last.grid_row;
        n_out.grid_ok  = w_last.grid_ok;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_image_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.image_ok |-> o_data.image_u == 32'sd0 && o_data.image_v == 32'sd0)
        else $error("image coordinates set on a failed depth check");

    a_grid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.grid_ok |-> o_data.grid_col == 9'd0 && o_data.grid_row == 9'd0)
        else $error("grid cell set outside the grid");

    a_hold_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r5_prod_u) && $stable(r_side[0]) && $stable(r5_v))
        else $error("pipeline moved while the output was held");
`endif

endmodule

@@ tb/sv/tb_world_point_projection.sv @@
// testbench for world_point_projection: predicts each result and checks it in order
`timescale 1ns / 1ps
module tb_world_point_projection;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 100;
    localparam logic [15:0] ONE_Q14 = 16'sd16384;

    class projection_check;
        logic [31:0]         regs [8];
        wpp_pkg::t_out_item  pending [$];
        int                  errors;

        function void load_reset();
            regs[wpp_pkg::CFG_FOCAL_X]      = wpp_pkg::RST_FOCAL_X;
            regs[wpp_pkg::CFG_FOCAL_Y]      = wpp_pkg::RST_FOCAL_Y;
            regs[wpp_pkg::CFG_CENTER_X]     = wpp_pkg::RST_CENTER_X;
            regs[wpp_pkg::CFG_CENTER_Y]     = wpp_pkg::RST_CENTER_Y;
            regs[wpp_pkg::CFG_GRID_X_ORG]   = wpp_pkg::RST_GRID_X_ORG;
            regs[wpp_pkg::CFG_GRID_Y_ORG]   = wpp_pkg::RST_GRID_Y_ORG;
            regs[wpp_pkg::CFG_GRID_SCALE_X] = wpp_pkg::RST_GRID_SCALE_X;
            regs[wpp_pkg::CFG_GRID_SCALE_Y] = wpp_pkg::RST_GRID_SCALE_Y;
            errors = 0;
        endfunction

        function longint clamp32(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        // f*a/z floored, plus center, saturated
        function logic [31:0] pinhole(logic [31:0] f, logic [31:0] c, longint a, longint z);
            logic [63:0]        mag;
            logic [63:0]        prod;
            logic [63:0]        q;
            logic [63:0]        r;
            logic signed [66:0] val;
            mag  = (a < 0) ? 64'(-a) : 64'(a);
            prod = {32'd0, f} * mag;
            q    = prod / 64'(z);
            r    = prod % 64'(z);
            val  = $signed({3'b000, q});
            if (a < 0) val = -val - ((r != 0) ? 67'sd1 : 67'sd0);
            val = val + $signed({35'd0, c});
            if (val > 67'sd2147483647) return 32'h7FFF_FFFF;
            if (val < -67'sd2147483648) return 32'h8000_0000;
            return val[31:0];
        endfunction

        function logic [63:0] cell_of(longint a, logic [31:0] org, logic [31:0] scale,
                                      output logic ok);
            longint      d;
            logic [63:0] mag;
            logic [63:0] prod;
            d    = a - longint'($signed(org));
            mag  = (d < 0) ? 64'(-d) : 64'(d);
            prod = mag * {32'd0, scale};
            if (d < 0 && prod != 0) begin
                ok = 1'b0;
                return 64'd0;
            end
            ok = (prod >> 32) < 64'd512;
            return prod >> 32;
        endfunction

        function wpp_pkg::t_out_item project_point(wpp_pkg::t_in_item it);
            logic [47:0]        rows [3];
            longint             rot [3][3];
            longint             diff [3];
            longint             cam [3];
            longint             acc;
            logic               ok_c;
            logic               ok_r;
            logic [63:0]        col;
            logic [63:0]        row;
            wpp_pkg::t_out_item o;
            rows[0] = it.rot_row0;
            rows[1] = it.rot_row1;
            rows[2] = it.rot_row2;
            diff[0] = longint'(it.point_x) - longint'(it.trans_x);
            diff[1] = longint'(it.point_y) - longint'(it.trans_y);
            diff[2] = longint'(it.point_z) - longint'(it.trans_z);
            for (int i = 0; i < 3; i++)
                for (int k = 0; k < 3; k++)
                    rot[i][k] = longint'($signed(rows[i][16*k +: 16]));
            for (int k = 0; k < 3; k++) begin
                acc = 0;
                for (int i = 0; i < 3; i++) acc += rot[i][k] * diff[i];
                cam[k] = clamp32(acc >>> 14);
            end
            o = '0;
            o.image_ok = cam[2] > longint'(it.min_depth) && cam[2] > wpp_pkg::DEPTH_EPS_RAW;
            if (o.image_ok) begin
                o.image_u = pinhole(regs[wpp_pkg::CFG_FOCAL_X], regs[wpp_pkg::CFG_CENTER_X],
                                    cam[0], cam[2]);
                o.image_v = pinhole(regs[wpp_pkg::CFG_FOCAL_Y], regs[wpp_pkg::CFG_CENTER_Y],
                                    cam[1], cam[2]);
            end
            col = cell_of(cam[0], regs[wpp_pkg::CFG_GRID_X_ORG],
                          regs[wpp_pkg::CFG_GRID_SCALE_X], ok_c);
            row = cell_of(cam[1], regs[wpp_pkg::CFG_GRID_Y_ORG],
                          regs[wpp_pkg::CFG_GRID_SCALE_Y], ok_r);
            o.grid_ok = ok_c && ok_r;
            if (o.grid_ok) begin
                o.grid_col = col[8:0];
                o.grid_row = row[8:0];
            end
            return o;
        endfunction

        function void note_point(wpp_pkg::t_in_item it);
            pending.push_back(project_point(it));
        endfunction

        function void check_result(wpp_pkg::t_out_item got);
            wpp_pkg::t_out_item want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got.image_u !== want.image_u || got.image_v !== want.image_v ||
                got.image_ok !== want.image_ok || got.grid_col !== want.grid_col ||
                got.grid_row !== want.grid_row || got.grid_ok !== want.grid_ok) begin
                errors++;
                if (errors <= 10) $display("result differs: expected %p got %p", want, got);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    wpp_pkg::t_in_item  i_data = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    wpp_pkg::t_out_item o_data;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;

    projection_check sb = new();
    bit hold_req = 1'b0;
    bit rx_quiet = 1'b0;
    bit tx_quiet = 1'b0;

    world_point_projection i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // result side: check accepted items, stall at random
    initial begin
        int burst;
        int r;
        burst = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) sb.check_result(o_data);
            if (hold_req) begin
                hold_req = 1'b0;
                burst = 400;
            end
            if (burst == 0 && !rx_quiet) begin
                r = $urandom_range(0, 99);
                if (r == 0) burst = $urandom_range(20, 80);
                else if (r < 25) burst = $urandom_range(1, 3);
            end
            if (burst > 0) begin
                i_stall <= 1'b1;
                burst--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                idle = 0;
            else
                idle++;
            if (idle >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic logic [47:0] pack_row(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        return {c, b, a};
    endfunction

    function automatic wpp_pkg::t_in_item mk_point(int px, int py, int pz,
                                                   int tx, int ty, int tz,
                                                   logic [30:0] md);
        wpp_pkg::t_in_item it;
        it.rot_row0 = pack_row(ONE_Q14, 16'd0, 16'd0);
        it.rot_row1 = pack_row(16'd0, ONE_Q14, 16'd0);
        it.rot_row2 = pack_row(16'd0, 16'd0, ONE_Q14);
        it.trans_x = tx; it.trans_y = ty; it.trans_z = tz;
        it.point_x = px; it.point_y = py; it.point_z = pz;
        it.min_depth = md;
        return it;
    endfunction

    function automatic int srand(int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    function automatic wpp_pkg::t_in_item random_point();
        wpp_pkg::t_in_item it;
        logic [15:0]       m [3][3];
        int                perm [3];
        int                j;
        int                tmp;
        if ($urandom_range(0, 99) < 15) begin
            it.rot_row0 = 48'({$urandom, $urandom});
            it.rot_row1 = 48'({$urandom, $urandom});
            it.rot_row2 = 48'({$urandom, $urandom});
            it.trans_x = $urandom; it.trans_y = $urandom; it.trans_z = $urandom;
            it.point_x = $urandom; it.point_y = $urandom; it.point_z = $urandom;
            it.min_depth = 31'($urandom);
            return it;
        end
        // signed permutation rotation with random noise on some entries
        perm = '{0, 1, 2};
        for (int i = 2; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
        end
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++) begin
                m[i][k] = ($urandom_range(0, 1) != 0) ? 16'(srand(2000)) : 16'd0;
                if (perm[i] == k)
                    m[i][k] = m[i][k] + (($urandom_range(0, 3) == 0) ? -ONE_Q14 : ONE_Q14);
            end
        it.rot_row0 = pack_row(m[0][0], m[0][1], m[0][2]);
        it.rot_row1 = pack_row(m[1][0], m[1][1], m[1][2]);
        it.rot_row2 = pack_row(m[2][0], m[2][1], m[2][2]);
        it.trans_x = srand(1 << 22); it.trans_y = srand(1 << 22); it.trans_z = srand(1 << 22);
        it.point_x = it.trans_x + int'($urandom_range(0, 65 << 16)) - (5 << 16);
        it.point_y = it.trans_y + srand(35 << 16);
        it.point_z = it.trans_z + int'($urandom_range(0, 85 << 16)) - (5 << 16);
        it.min_depth = ($urandom_range(0, 1) != 0) ? 31'($urandom_range(0, 1 << 17))
                                                   : 31'($urandom);
        return it;
    endfunction

    // caller sits just after a rising edge
    task automatic send_point(wpp_pkg::t_in_item it);
        int r;
        int gap;
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (o_stall);
        sb.note_point(it);
        r = $urandom_range(0, 99);
        if (tx_quiet || r < 70) gap = 0;
        else if (r < 90) gap = $urandom_range(1, 3);
        else if (r < 98) gap = $urandom_range(4, 10);
        else gap = $urandom_range(20, 60);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic end_stream();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [31:0] vals [8]);
        for (int i = 0; i < 8; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= 3'(i);
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.regs[i] = vals[i];
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        wpp_pkg::t_in_item it;
        logic [31:0]       vals [8];
        sb.load_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: depth thresholds, grid edges, saturation
        tx_quiet = 1'b1;
        send_point(mk_point(0, 0, 65, 0, 0, 0, 0));
        send_point(mk_point(0, 0, 66, 0, 0, 0, 0));
        send_point(mk_point(0, 0, 1 << 16, 0, 0, 0, 31'd65536));
        send_point(mk_point(0, 0, (1 << 16) + 1, 0, 0, 0, 31'd65536));
        send_point(mk_point(3 << 16, -(2 << 16), 10 << 16, 1 << 16, 1 << 16, 0, 0));
        send_point(mk_point(0, -(20 << 16), -(4 << 16), 0, 0, 0, 0));
        send_point(mk_point(-1, -(20 << 16), 5 << 16, 0, 0, 0, 0));
        send_point(mk_point(32'sh0033_3332, 32'sh000B_3332, 5 << 16, 0, 0, 0, 0));
        send_point(mk_point(32'sh0033_3334, 0, 5 << 16, 0, 0, 0, 0));
        send_point(mk_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                            32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF));
        send_point(mk_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                            32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0));
        send_point(mk_point(32'sh7FFF_FFFF, 32'sh8000_0000, 67, 0, 0, 0, 0));
        send_point(mk_point(32'sh8000_0000, 32'sh7FFF_FFFF, 67, 0, 0, 0, 0));
        it = mk_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                      32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
        it.rot_row0 = '1; it.rot_row1 = '1; it.rot_row2 = '1;
        send_point(it);
        it.rot_row0 = {3{16'h8000}}; it.rot_row1 = {3{16'h8000}}; it.rot_row2 = {3{16'h8000}};
        it.min_depth = 0;
        send_point(it);
        it.rot_row0 = {3{16'h7FFF}}; it.rot_row1 = {3{16'h7FFF}}; it.rot_row2 = {3{16'h7FFF}};
        send_point(it);
        tx_quiet = 1'b0;
        end_stream();

        for (int phase = 0; phase < 6; phase++) begin
            for (int i = 0; i < 8; i++) vals[i] = $urandom;
            case (phase)
                1: vals = '{default: 32'd0};
                2: vals = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
                3: vals = '{32'd1, 32'd1, 32'd0, 32'd0,
                            32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd1};
                4: vals = '{$urandom_range(1 << 16, 2000 << 16), $urandom_range(1 << 16, 2000 << 16),
                            $urandom_range(0, 1000 << 16), $urandom_range(0, 500 << 16),
                            32'(srand(10 << 16)), 32'(srand(30 << 16)),
                            $urandom_range(0, 20 << 16), $urandom_range(0, 20 << 16)};
                default: ;
            endcase
            if (phase != 0) write_regs(vals);
            rx_quiet = (phase == 3);
            tx_quiet = (phase == 4);
            if (phase == 5) hold_req = 1'b1;
            for (int n = 0; n < 240; n++) send_point(random_point());
            end_stream();
        end
        rx_quiet = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
